[sv/zpd_pkg.sv]
package zpd_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int WS_W = 7;
	localparam int MT_W = 13;
	localparam int ZT_W = 15;
	localparam int SD_W = 15;
	localparam int Z_W = 16;
	localparam int OUTCOME_W = 3;

	localparam int Z_FRAC = 12;
	localparam int RAD_SHIFT = 8;

	localparam logic [WS_W-1:0] WS_RESET = WS_W'(16);
	localparam logic signed [MT_W-1:0] MT_RESET = '0;
	localparam logic [ZT_W-1:0] ZT_RESET = ZT_W'(768);

	localparam int SD_MAX = 32767;
	localparam int Z_POS_MAX = 32767;
	localparam int Z_NEG_MAG = 32768;

	localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [1:0] REG_MIN_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_Z_THRESHOLD = 2'd2;

	localparam logic [OUTCOME_W-1:0] OUT_IGNORED = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_FILLING = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_DEGENERATE = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_BELOW = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_SIGNAL = 3'd4;
	localparam logic [OUTCOME_W-1:0] OUT_NOT_SIGNAL = 3'd5;

endpackage

[sv/zpd_ram.sv]
module zpd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/zpd_divider.sv]
module zpd_divider #(
	parameter int NUM_W = 30,
	parameter int DEN_W = 15,
	parameter int STEP_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [STEP_W-1:0] steps,
	output logic [NUM_W-1:0]  quo,
	output logic              done
);

	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;

	logic [DEN_W:0] t1, r1, t2, r2;
	logic           ge1, ge2;

	always_comb begin
		t1 = {rem_q, num_q[NUM_W-1]};
		ge1 = t1 >= {1'b0, den_q};
		r1 = ge1 ? t1 - {1'b0, den_q} : t1;
		t2 = {r1[DEN_W-1:0], num_q[NUM_W-2]};
		ge2 = t2 >= {1'b0, den_q};
		r2 = ge2 ? t2 - {1'b0, den_q} : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_W'(1);
			done_q <= (cnt_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 2;
			rem_q <= r2[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-3:0], ge1, ge2};
		end
	end

	assign quo = quo_q;
	assign done = done_q;

endmodule

[sv/zpd_sqrt.sv]
module zpd_sqrt #(
	parameter int RAD_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RAD_W-1:0]   rad,
	output logic [RAD_W/2-1:0] root,
	output logic               done
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [REM_W+1:0] cur, trial, diff;
	logic             ge;

	always_comb begin
		cur = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
		trial = (REM_W + 2)'({root_q, 2'b01});
		ge = cur >= trial;
		diff = ge ? cur - trial : cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_W'(ROOT_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad;
			root_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= rad_q << 2;
			rem_q <= diff[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

[sv/zscore_peak_detector.sv]
// Channel    Direction  Signals                                     Transfer
// sample     in         sample_valid, sample_ready, sample          valid & ready
// result     out        result_valid, result_ready, outcome ...     valid & ready
// apb        in/out     psel, penable, pwrite, paddr, pwdata ...    access phase
//
// A zero sample goes straight to the final state, and a filling sample passes through
// the fill state first. A scored sample uses the shared divider (two quotient bits a
// cycle) for the mean, the mean of squares and the z-score, and the square root unit
// (one root bit a cycle) for the standard deviation. One request is worked on at a time;
// the next one is taken while the previous result waits in the output register. Reset
// empties the window and loads the register defaults. A stalled result holds the block
// in its final state until the output register frees.
module zscore_peak_detector #(
	parameter int WINDOW_MAX = zpd_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = zpd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [SAMPLE_BITS-1:0]          sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [zpd_pkg::OUTCOME_W-1:0]   outcome,
	output logic                            is_signal,
	output logic                            stats_valid,
	output logic [SAMPLE_BITS-1:0]          window_mean,
	output logic [zpd_pkg::SD_W-1:0]        window_stddev,
	output logic signed [zpd_pkg::Z_W-1:0]  z_score,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [zpd_pkg::PADDR_W-1:0]     paddr,
	input  logic [zpd_pkg::PDATA_W-1:0]     pwdata,
	output logic [zpd_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	import zpd_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(WINDOW_MAX);
	localparam int NW = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = SB + AW;
	localparam int SQ_W = 2 * SB + AW;
	localparam int Z_NUM_W = SB + Z_FRAC;
	localparam int K_SUM = SUM_W + (SUM_W % 2);
	localparam int K_SQ = SQ_W + (SQ_W % 2);
	localparam int K_Z = Z_NUM_W + (Z_NUM_W % 2);
	localparam int DW = (K_SQ > K_Z) ? K_SQ : K_Z;
	localparam int DVW = (NW > SD_W) ? NW : SD_W;
	localparam int STW = $clog2(DW / 2 + 1);
	localparam int RAD_W = 2 * SB + RAD_SHIFT;
	localparam int ROOT_W = RAD_W / 2;
	localparam int SDC_W = (ROOT_W > 16) ? ROOT_W : 16;
	localparam int CW = (NW > WS_W) ? NW : WS_W;
	localparam int QC_W = (Z_NUM_W > 17) ? Z_NUM_W : 17;
	localparam int TW = ((SB > MT_W) ? SB : MT_W) + 2;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_FILL   = 14'b00000000000010,
		S_MEAN   = 14'b00000000000100,
		S_MEANW  = 14'b00000000001000,
		S_VAR    = 14'b00000000010000,
		S_VARW   = 14'b00000000100000,
		S_MSQ    = 14'b00000001000000,
		S_SUBV   = 14'b00000010000000,
		S_SQRTW  = 14'b00000100000000,
		S_CHECK  = 14'b00001000000000,
		S_ZW     = 14'b00010000000000,
		S_DECIDE = 14'b00100000000000,
		S_REPL   = 14'b01000000000000,
		S_DONE   = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [WS_W-1:0]        window_size_q;
	logic signed [MT_W-1:0] min_threshold_q;
	logic [ZT_W-1:0]        z_threshold_q;

	logic [NW-1:0]    fill_q;
	logic [AW-1:0]    ptr_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sumsq_q;

	logic [SB-1:0]     s_q;
	logic [2*SB-1:0]   ssq_q;
	logic [SB-1:0]     mean_q;
	logic [2*SB-1:0]   varq_q;
	logic [2*SB-1:0]   prod_q;
	logic [SD_W-1:0]   sd_q;
	logic              zneg_q;
	logic signed [Z_W-1:0] z_q;
	logic [OUTCOME_W-1:0]  res_outcome_q;
	logic              res_stats_q;

	logic                  out_valid_q;
	logic [OUTCOME_W-1:0]  outcome_q;
	logic                  is_signal_q;
	logic                  stats_q;
	logic [SB-1:0]         mean_o_q;
	logic [SD_W-1:0]       sd_o_q;
	logic signed [Z_W-1:0] z_o_q;

	logic [CW-1:0] ws_x;
	logic [NW-1:0] n_eff;
	logic          accept;
	logic          cfg_wr;
	logic          out_load;

	logic           div_start;
	logic [DW-1:0]  div_num;
	logic [DVW-1:0] div_den;
	logic [STW-1:0] div_steps;
	logic [DW-1:0]  div_quo;
	logic           div_done;

	logic              sqrt_start;
	logic [2*SB-1:0]   var_val;
	logic [RAD_W-1:0]  sqrt_rad;
	logic [ROOT_W-1:0] sqrt_root;
	logic              sqrt_done;
	logic [SDC_W-1:0]  root_x;
	logic [SD_W-1:0]   sd_sat;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [SB-1:0]     ram_rdata;

	logic [SB-1:0]     mul_a;
	logic [2*SB-1:0]   mul_p;
	logic [SB:0]       mag_full;
	logic [SB-1:0]     zmag;
	logic [QC_W-1:0]   q_x;
	logic signed [Z_W-1:0] z_sat;
	logic signed [TW-1:0]  s_t, mean_t, mt_t;
	logic              below;
	logic              is_sig;
	logic              degen;
	logic [NW-1:0]     ptr_inc;

	assign accept = sample_valid && sample_ready;
	assign sample_ready = (state_q == S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result_ready);

	always_comb begin
		ws_x = CW'(window_size_q);
		if (ws_x < CW'(2)) begin
			n_eff = NW'(2);
		end else if (ws_x > CW'(WINDOW_MAX)) begin
			n_eff = NW'(WINDOW_MAX);
		end else begin
			n_eff = ws_x[NW-1:0];
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WINDOW_SIZE:   prdata = PDATA_W'(window_size_q);
			REG_MIN_THRESHOLD: prdata = PDATA_W'(min_threshold_q);
			REG_Z_THRESHOLD:   prdata = PDATA_W'(z_threshold_q);
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num = DW'(sum_q) << (DW - K_SUM);
		div_den = DVW'(n_eff);
		div_steps = STW'(K_SUM / 2);
		if (state_q == S_MEAN) begin
			div_start = 1'b1;
		end else if (state_q == S_VAR) begin
			div_start = 1'b1;
			div_num = DW'(sumsq_q) << (DW - K_SQ);
			div_steps = STW'(K_SQ / 2);
		end else if (state_q == S_CHECK) begin
			div_start = !degen;
			div_num = DW'({zmag, {Z_FRAC{1'b0}}}) << (DW - K_Z);
			div_den = DVW'(sd_q);
			div_steps = STW'(K_Z / 2);
		end
	end

	always_comb begin
		var_val = (varq_q >= prod_q) ? varq_q - prod_q : '0;
		sqrt_rad = {var_val, {RAD_SHIFT{1'b0}}};
		sqrt_start = (state_q == S_SUBV);
		root_x = SDC_W'(sqrt_root);
		sd_sat = (root_x > SDC_W'(SD_MAX)) ? SD_W'(SD_MAX) : root_x[SD_W-1:0];
	end

	always_comb begin
		mul_a = (state_q == S_MSQ) ? mean_q : ram_rdata;
		mul_p = (2 * SB)'(mul_a) * (2 * SB)'(mul_a);
		mag_full = (s_q >= mean_q) ? {1'b0, s_q} - {1'b0, mean_q}
		                           : {1'b0, mean_q} - {1'b0, s_q};
		zmag = mag_full[SB-1:0];
		degen = (mean_q == '0) || (sd_q == '0);
		q_x = QC_W'(div_quo[Z_NUM_W-1:0]);
		if (!zneg_q) begin
			z_sat = (q_x > QC_W'(Z_POS_MAX)) ? Z_W'(Z_POS_MAX) : Z_W'(q_x);
		end else begin
			z_sat = (q_x > QC_W'(Z_NEG_MAG)) ? Z_W'(Z_NEG_MAG) : Z_W'(-q_x);
		end
		s_t = TW'({1'b0, s_q});
		mean_t = TW'({1'b0, mean_q});
		mt_t = TW'(min_threshold_q);
		below = s_t < (mean_t + mt_t);
		is_sig = z_q > $signed({1'b0, z_threshold_q});
		ptr_inc = NW'(ptr_q) + NW'(1);
		ram_we = (state_q == S_FILL) || (state_q == S_REPL);
		ram_waddr = (state_q == S_FILL) ? fill_q[AW-1:0] : ptr_q;
	end

	zpd_ram #(
		.WIDTH(SB),
		.DEPTH(WINDOW_MAX)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(s_q),
		.re(accept),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	zpd_divider #(
		.NUM_W(DW),
		.DEN_W(DVW),
		.STEP_W(STW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.steps(div_steps),
		.quo(div_quo),
		.done(div_done)
	);

	zpd_sqrt #(
		.RAD_W(RAD_W)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.rad(sqrt_rad),
		.root(sqrt_root),
		.done(sqrt_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			window_size_q <= WS_RESET;
			min_threshold_q <= MT_RESET;
			z_threshold_q <= ZT_RESET;
			fill_q <= '0;
			ptr_q <= '0;
			sum_q <= '0;
			sumsq_q <= '0;
			res_outcome_q <= OUT_IGNORED;
			res_stats_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_WINDOW_SIZE: begin
						window_size_q <= pwdata[WS_W-1:0];
						fill_q <= '0;
						ptr_q <= '0;
						sum_q <= '0;
						sumsq_q <= '0;
					end
					REG_MIN_THRESHOLD: min_threshold_q <= pwdata[MT_W-1:0];
					REG_Z_THRESHOLD:   z_threshold_q <= pwdata[ZT_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_stats_q <= 1'b0;
						if (sample == '0) begin
							res_outcome_q <= OUT_IGNORED;
							state_q <= S_DONE;
						end else if (fill_q < n_eff) begin
							res_outcome_q <= OUT_FILLING;
							state_q <= S_FILL;
						end else begin
							state_q <= S_MEAN;
						end
					end
				end
				S_FILL: begin
					sum_q <= sum_q + SUM_W'(s_q);
					sumsq_q <= sumsq_q + SQ_W'(ssq_q);
					fill_q <= fill_q + NW'(1);
					ptr_q <= '0;
					state_q <= S_DONE;
				end
				S_MEAN: state_q <= S_MEANW;
				S_MEANW: begin
					if (div_done) begin
						state_q <= S_VAR;
					end
				end
				S_VAR: state_q <= S_VARW;
				S_VARW: begin
					if (div_done) begin
						state_q <= S_MSQ;
					end
				end
				S_MSQ: state_q <= S_SUBV;
				S_SUBV: state_q <= S_SQRTW;
				S_SQRTW: begin
					if (sqrt_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (degen) begin
						res_outcome_q <= OUT_DEGENERATE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ZW;
					end
				end
				S_ZW: begin
					if (div_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					res_stats_q <= 1'b1;
					if (below) begin
						res_outcome_q <= OUT_BELOW;
						state_q <= S_REPL;
					end else if (is_sig) begin
						res_outcome_q <= OUT_SIGNAL;
						state_q <= S_DONE;
					end else begin
						res_outcome_q <= OUT_NOT_SIGNAL;
						state_q <= S_REPL;
					end
				end
				S_REPL: begin
					sum_q <= sum_q + SUM_W'(s_q) - SUM_W'(ram_rdata);
					sumsq_q <= sumsq_q + SQ_W'(ssq_q) - SQ_W'(prod_q);
					ptr_q <= (ptr_inc >= n_eff) ? '0 : ptr_inc[AW-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= sample;
			ssq_q <= (2 * SB)'(sample) * (2 * SB)'(sample);
		end
		if (state_q == S_MEANW && div_done) begin
			mean_q <= div_quo[SB-1:0];
		end
		if (state_q == S_VARW && div_done) begin
			varq_q <= div_quo[2*SB-1:0];
		end
		if (state_q == S_MSQ || state_q == S_DECIDE) begin
			prod_q <= mul_p;
		end
		if (state_q == S_SQRTW && sqrt_done) begin
			sd_q <= sd_sat;
		end
		if (state_q == S_CHECK) begin
			zneg_q <= (s_q < mean_q);
		end
		if (state_q == S_ZW && div_done) begin
			z_q <= z_sat;
		end
		if (out_load) begin
			outcome_q <= res_outcome_q;
			is_signal_q <= (res_outcome_q == OUT_SIGNAL);
			stats_q <= res_stats_q;
			mean_o_q <= res_stats_q ? mean_q : '0;
			sd_o_q <= res_stats_q ? sd_q : '0;
			z_o_q <= res_stats_q ? z_q : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign outcome = outcome_q;
	assign is_signal = is_signal_q;
	assign stats_valid = stats_q;
	assign window_mean = mean_o_q;
	assign window_stddev = sd_o_q;
	assign z_score = z_o_q;

endmodule

[sv/zpd_checker.sv]
module zpd_checker #(
	parameter int SAMPLE_BITS = zpd_pkg::SAMPLE_BITS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            sample_valid,
	input logic                            sample_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [zpd_pkg::OUTCOME_W-1:0]   outcome,
	input logic                            is_signal,
	input logic                            stats_valid,
	input logic [SAMPLE_BITS-1:0]          window_mean,
	input logic [zpd_pkg::SD_W-1:0]        window_stddev,
	input logic signed [zpd_pkg::Z_W-1:0]  z_score
);

	import zpd_pkg::*;

	// Only one request is in flight, so the block is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample_ready high in the cycle after a request was taken");

	a_signal_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (is_signal == (outcome == OUT_SIGNAL)))
		else $error("is_signal disagrees with outcome");

	a_stats_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (stats_valid == (outcome == OUT_BELOW ||
			outcome == OUT_SIGNAL || outcome == OUT_NOT_SIGNAL)))
		else $error("stats_valid disagrees with outcome");

	a_stale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !stats_valid |->
			window_mean == '0 && window_stddev == '0 && z_score == '0)
		else $error("statistics fields not zero without fresh statistics");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(outcome) &&
			$stable(z_score))
		else $error("stalled result changed");

endmodule

bind zscore_peak_detector zpd_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_zpd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample_valid),
	.sample_ready(sample_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.outcome(outcome),
	.is_signal(is_signal),
	.stats_valid(stats_valid),
	.window_mean(window_mean),
	.window_stddev(window_stddev),
	.z_score(z_score)
);
